// File: rtl/gam_pkg.sv
// ----------------------------------------------------------------------------
// gam_pkg
// Shared types, constants and helpers of the gated auto-gain mixer.
// ----------------------------------------------------------------------------
package gam_pkg;

    localparam int DEF_MAX_CHANNELS = 10;
    localparam int DEF_SAMPLE_BITS  = 24;

    // Fixed-point formats
    localparam int GAIN_FRAC = 23;
    localparam int RAMP_FRAC = 30;
    localparam int OUT_SCALE = 1020054733;   // 0.95 in Q30

    // Field widths
    localparam int CH_FIELD_W  = 4;
    localparam int SLEW_W      = 16;
    localparam int RATE_W      = 18;
    localparam int LEN_W       = 24;
    localparam int TARGET_W    = 25;
    localparam int CNT_FIELD_W = 4;
    localparam int NCOUNT_W    = 5;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_SLEW   = 2'd2;

    // Request types
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_GATE   = 1'b1;

    // Divider widths: slew*rate product, ramp step over a ramp length
    localparam int DIV_A_W  = SLEW_W + RATE_W;
    localparam int DIV_B_W  = LEN_W;
    localparam int DIV_CNT_W = 6;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    // Ramp length: floor(p/1000) = floor(floor(p/8) * LEN_RECIP / 2^LEN_RECIP_SH),
    // exact for every slew*rate product
    localparam int          LEN_RECIP_SH = 38;
    localparam logic [31:0] LEN_RECIP    = 32'd2199023256;

    // Per-channel ramp record held in the state memory
    typedef struct packed {
        logic               active;
        logic signed [31:0] gain;
        logic signed [31:0] step;
        logic [LEN_W-1:0]   len;
        logic [LEN_W-1:0]   done;
    } t_chan_rec;

    // Divider request
    typedef struct packed {
        logic               start;
        logic [DIV_A_W-1:0] dividend;
        logic [DIV_B_W-1:0] divisor;
    } t_div_req;

    // Rounded 1/n in Q23 for the open-gate count n
    function automatic logic [TARGET_W-1:0] recip_q23(input logic [NCOUNT_W-1:0] n);
        logic [TARGET_W-1:0] r;
        unique case (n)
            5'd1:    r = 25'd8388608;
            5'd2:    r = 25'd4194304;
            5'd3:    r = 25'd2796203;
            5'd4:    r = 25'd2097152;
            5'd5:    r = 25'd1677722;
            5'd6:    r = 25'd1398101;
            5'd7:    r = 25'd1198373;
            5'd8:    r = 25'd1048576;
            5'd9:    r = 25'd932068;
            5'd10:   r = 25'd838861;
            5'd11:   r = 25'd762601;
            5'd12:   r = 25'd699051;
            5'd13:   r = 25'd645278;
            5'd14:   r = 25'd599186;
            5'd15:   r = 25'd559241;
            5'd16:   r = 25'd524288;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/gam_if.sv
// ----------------------------------------------------------------------------
// gam_if
// Channel interfaces of the mixer: input items, mixed results, configuration.
// ----------------------------------------------------------------------------
interface gam_in_if #(
    parameter int SAMPLE_BITS = gam_pkg::DEF_SAMPLE_BITS
);
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [gam_pkg::CH_FIELD_W-1:0]      channel;
    logic signed [SAMPLE_BITS-1:0]       sample;
    logic                                frame_last;
    logic                                gate_on;
    logic                                slew_given;
    logic [gam_pkg::SLEW_W-1:0]          slew_ms;

    modport source (output valid, req_type, channel, sample, frame_last, gate_on,
                    slew_given, slew_ms, input ready);
    modport sink   (input valid, req_type, channel, sample, frame_last, gate_on,
                    slew_given, slew_ms, output ready);
endinterface

interface gam_out_if #(
    parameter int SAMPLE_BITS = gam_pkg::DEF_SAMPLE_BITS
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] mix_out;

    modport source (output valid, mix_out, input ready);
    modport sink   (input valid, mix_out, output ready);
endinterface

interface gam_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gam_pkg::CFG_IDX_W-1:0]   index;
    logic [gam_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/gam_div.sv
// ----------------------------------------------------------------------------
// gam_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gam_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gam_pkg::t_div_req            i_req,
    output logic                         o_done,
    output logic [gam_pkg::DIV_A_W-1:0]  o_quo
);
    import gam_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DIV_CNT_W-1:0]   r_cnt;
    logic [DIV_B_W-1:0]     r_rem;
    logic [DIV_B_W-1:0]     r_b;
    logic [DIV_A_W-1:0]     r_q;
    logic [DIV_B_W:0]       sh;
    logic [DIV_B_W:0]       trial;

    // Trial subtract of the shifted remainder
    assign sh    = {r_rem, r_q[DIV_A_W-1]};
    assign trial = sh - {1'b0, r_b};

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_A_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_b   <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!trial[DIV_B_W]) begin
                r_rem <= trial[DIV_B_W-1:0];
                r_q   <= {r_q[DIV_A_W-2:0], 1'b1};
            end else begin
                r_rem <= sh[DIV_B_W-1:0];
                r_q   <= {r_q[DIV_A_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// File: rtl/gated_auto_gain_mixer.sv
// ----------------------------------------------------------------------------
// gated_auto_gain_mixer
// Gated mixer with automatic 1/n gain and linear per-channel gain ramps.
// ----------------------------------------------------------------------------
// Channels: i_in carries one transaction per item, either a channel sample or
// a gate event; o_out carries one mixed sample per frame; i_cfg writes the
// channel_count, sample_rate and global_slew_ms registers while idle.
// A sample item passes the state memory read, the gain update and multiply, and
// the accumulate; one with frame_last then scales the sum by 0.95 and rounds and
// saturates it into the output register. A frame_last sample on a channel
// outside the mix skips straight to the scale, round and saturate.
// A gate event walks all MAX_CHANNELS entries of the ramp memory. Each entry is
// read and its slew checked, which ends an entry with zero slew; else a
// reciprocal multiply gives the ramp length, which ends an entry whose length
// comes out zero; else a pass of the bit-serial divider gives the ramp step.
// The divider and single memory port pace the walk; i_in and i_cfg are not ready.
// Reset clears the gates, the accumulator and the per-entry valid bits, so the
// ramp memory reads as zero until written; no clearing pass is needed.
// When o_out stalls, the finished result holds in the output register; a new
// item is accepted and only a further frame result waits for it to drain.
// ----------------------------------------------------------------------------
module gated_auto_gain_mixer #(
    parameter int MAX_CHANNELS = gam_pkg::DEF_MAX_CHANNELS,
    parameter int SAMPLE_BITS  = gam_pkg::DEF_SAMPLE_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gam_in_if.sink     i_in,
    gam_out_if.source  o_out,
    gam_cfg_if.sink    i_cfg
);
    import gam_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PRD_W = SAMPLE_BITS + 32;
    localparam int V_W   = SAMPLE_BITS + 2;
    localparam int SUM_W = ((V_W > 32) ? V_W : 32) + 1;
    localparam int OP_W  = 63;
    localparam int OV_W  = OP_W - RAMP_FRAC;
    localparam int LM_W  = (DIV_A_W - 3) + 32;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_OUT  = 4'd3;
    localparam logic [3:0] S_FIN  = 4'd4;
    localparam logic [3:0] G_RD   = 4'd5;
    localparam logic [3:0] G_CHK  = 4'd6;
    localparam logic [3:0] G_DIV1 = 4'd7;
    localparam logic [3:0] G_DIV2 = 4'd8;

    localparam logic signed [SUM_W-1:0] ACC_HI = {{(SUM_W-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [SUM_W-1:0] ACC_LO = {{(SUM_W-32){1'b1}}, 32'h8000_0000};
    localparam logic signed [OV_W-1:0]  OUT_HI =
        (OV_W'(1) << (SAMPLE_BITS - 1)) - OV_W'(1);
    localparam logic signed [OV_W-1:0]  OUT_LO = ~OUT_HI;

    // Configuration and gate state
    logic [CNT_FIELD_W-1:0]  r_cc;
    logic [RATE_W-1:0]       r_sr;
    logic [SLEW_W-1:0]       r_gslew;
    logic [SLEW_W-1:0]       r_slew [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_gate;

    // Ramp memory
    t_chan_rec               r_mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0] r_vld;
    t_chan_rec               r_rd;
    logic                    r_rd_vld;
    t_chan_rec               rd_rec;
    logic [CH_W-1:0]         rd_addr;
    logic                    mem_we;
    t_chan_rec               mem_wd;
    logic [CH_W-1:0]         mem_wa;

    // Sequencer and datapath
    logic [3:0]                    r_state;
    logic [CH_W-1:0]               r_ch;
    logic [CH_W-1:0]               r_idx;
    logic signed [SAMPLE_BITS-1:0] r_smp;
    logic                          r_last;
    logic signed [PRD_W-1:0]       r_prod;
    logic signed [31:0]            r_acc;
    logic signed [OP_W-1:0]        r_oprod;
    logic [DIV_A_W-1:0]            r_lprod;
    logic [LEN_W:0]                r_lquo;
    logic [LEN_W-1:0]              r_len;
    logic                          r_ovld;
    logic signed [SAMPLE_BITS-1:0] r_omix;

    logic [NCOUNT_W-1:0]           live;
    logic                          in_live;
    logic [CH_W-1:0]               in_ch;
    logic                          in_acc;
    logic                          cfg_acc;
    logic                          gate_wr;
    logic [NCOUNT_W-1:0]           nopen;
    logic [TARGET_W-1:0]           recip;
    logic signed [31:0]            dest_ch;
    logic signed [31:0]            dest_idx;
    t_chan_rec                     adv_rec;
    logic signed [PRD_W-1:0]       prod_rnd;
    logic signed [V_W-1:0]         contrib;
    logic signed [SUM_W-1:0]       acc_sum;
    logic signed [31:0]            acc_sat;
    logic signed [OP_W-1:0]        oprod_rnd;
    logic signed [OV_W-1:0]        ov;
    logic [SAMPLE_BITS-1:0]        ov_sat;
    logic signed [32:0]            diff;
    logic [32:0]                   diff_mag;
    logic [LM_W-1:0]               lmul;
    logic [LEN_W-1:0]              len_sat;
    logic [31:0]                   step_val;
    logic                          fin_go;
    t_div_req                      div_req;
    logic                          div_done;
    logic [DIV_A_W-1:0]            div_quo;

    // Handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;
    assign o_out.valid   = r_ovld;
    assign o_out.mix_out = r_omix;

    // Effective channel count and input channel check
    always_comb begin
        if (r_cc < CNT_FIELD_W'(2)) begin
            live = NCOUNT_W'(2);
        end else if ({1'b0, r_cc} > NCOUNT_W'(MAX_CHANNELS)) begin
            live = NCOUNT_W'(MAX_CHANNELS);
        end else begin
            live = {1'b0, r_cc};
        end
    end
    assign in_live = ({1'b0, i_in.channel} < live);
    assign in_ch   = i_in.channel[CH_W-1:0];
    assign gate_wr = in_acc && i_in.req_type == REQ_GATE && in_live;

    // Gain targets follow from the open gates
    assign nopen    = NCOUNT_W'($countones(r_gate));
    assign recip    = recip_q23(nopen);
    assign dest_ch  = r_gate[r_ch]  ? 32'({recip, 7'b0}) : '0;
    assign dest_idx = r_gate[r_idx] ? 32'({recip, 7'b0}) : '0;

    // Memory read, unwritten entries read as zero
    assign rd_addr = (r_state == S_IDLE) ? in_ch : r_idx;
    assign rd_rec  = r_rd_vld ? r_rd : '0;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[rd_addr];
            if (mem_we) begin
                r_vld[mem_wa] <= 1'b1;
            end
        end
    end

    // Advance the ramp of the sampled channel
    always_comb begin
        adv_rec = rd_rec;
        if (rd_rec.active) begin
            adv_rec.done = rd_rec.done + 1'b1;
            if (adv_rec.done >= rd_rec.len) begin
                adv_rec.gain   = dest_ch;
                adv_rec.active = 1'b0;
            end else begin
                adv_rec.gain = rd_rec.gain + rd_rec.step;
            end
        end
    end

    // Round the contribution and saturate the running sum
    assign prod_rnd = r_prod + PRD_W'(1 << (RAMP_FRAC - 1));
    assign contrib  = prod_rnd[PRD_W-1:RAMP_FRAC];
    assign acc_sum  = SUM_W'(r_acc) + SUM_W'(contrib);
    always_comb begin
        if (acc_sum > ACC_HI) begin
            acc_sat = ACC_HI[31:0];
        end else if (acc_sum < ACC_LO) begin
            acc_sat = ACC_LO[31:0];
        end else begin
            acc_sat = acc_sum[31:0];
        end
    end

    // Round and saturate the scaled frame sum
    assign oprod_rnd = r_oprod + OP_W'(1 << (RAMP_FRAC - 1));
    assign ov        = oprod_rnd[OP_W-1:RAMP_FRAC];
    always_comb begin
        if (ov > OUT_HI) begin
            ov_sat = OUT_HI[SAMPLE_BITS-1:0];
        end else if (ov < OUT_LO) begin
            ov_sat = OUT_LO[SAMPLE_BITS-1:0];
        end else begin
            ov_sat = ov[SAMPLE_BITS-1:0];
        end
    end
    assign fin_go = !r_ovld || o_out.ready;

    // Ramp restart arithmetic: length by reciprocal multiply, step by divider
    assign lmul     = LM_W'(r_lprod[DIV_A_W-1:3]) * LM_W'(LEN_RECIP);
    assign diff     = 33'(dest_idx) - 33'(rd_rec.gain);
    assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
    assign len_sat  = r_lquo[LEN_W] ? LEN_MAX : r_lquo[LEN_W-1:0];
    assign step_val = diff[32] ? 32'(-div_quo) : div_quo[31:0];

    // Divider request: ramp step
    always_comb begin
        div_req = '0;
        if (r_state == G_DIV1 && len_sat != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_A_W'(diff_mag);
            div_req.divisor  = len_sat;
        end
    end

    gam_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Memory write-back
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_idx;
        mem_wd = rd_rec;
        unique case (r_state)
            S_MUL: begin
                mem_we = 1'b1;
                mem_wa = r_ch;
                mem_wd = adv_rec;
            end
            G_CHK: begin
                if (r_slew[r_idx] == '0) begin
                    mem_we        = 1'b1;
                    mem_wd.active = 1'b0;
                    mem_wd.gain   = dest_idx;
                end
            end
            G_DIV1: begin
                if (len_sat == '0) begin
                    mem_we        = 1'b1;
                    mem_wd.active = 1'b0;
                    mem_wd.gain   = dest_idx;
                    mem_wd.len    = '0;
                    mem_wd.done   = '0;
                end
            end
            G_DIV2: begin
                if (div_done) begin
                    mem_we        = 1'b1;
                    mem_wd.active = 1'b1;
                    mem_wd.step   = step_val;
                    mem_wd.len    = r_len;
                    mem_wd.done   = '0;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Configuration registers and per-channel gate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc    <= CNT_FIELD_W'(2);
            r_sr    <= RATE_W'(44100);
            r_gslew <= '0;
            r_gate  <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_slew[i] <= '0;
            end
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg.index)
                    REG_CHANNEL_COUNT: r_cc    <= i_cfg.data[CNT_FIELD_W-1:0];
                    REG_SAMPLE_RATE:   r_sr    <= i_cfg.data[RATE_W-1:0];
                    REG_GLOBAL_SLEW:   r_gslew <= i_cfg.data[SLEW_W-1:0];
                    default:           r_cc    <= r_cc;
                endcase
            end
            // Gate event slew first, else a global slew write loads every channel
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                if (gate_wr && in_ch == CH_W'(i)) begin
                    r_slew[i] <= i_in.slew_given ? i_in.slew_ms : r_gslew;
                end else if (cfg_acc && i_cfg.index == REG_GLOBAL_SLEW) begin
                    r_slew[i] <= i_cfg.data[SLEW_W-1:0];
                end
            end
            if (gate_wr) begin
                r_gate[in_ch] <= i_in.gate_on;
            end
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_ovld  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (r_ovld && o_out.ready && !(r_state == S_FIN)) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.req_type == REQ_GATE) begin
                            if (in_live) begin
                                r_idx   <= '0;
                                r_state <= G_RD;
                            end
                        end else if (in_live) begin
                            r_state <= S_MUL;
                        end else if (i_in.frame_last) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_acc   <= acc_sat;
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    r_acc   <= '0;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Hand over to the output register once it is free
                    if (fin_go) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                G_RD: r_state <= G_CHK;
                G_CHK: begin
                    if (r_slew[r_idx] != '0) begin
                        r_state <= G_DIV1;
                    end else if (r_idx == CH_W'(MAX_CHANNELS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= G_RD;
                    end
                end
                G_DIV1: begin
                    if (len_sat != '0) begin
                        r_state <= G_DIV2;
                    end else if (r_idx == CH_W'(MAX_CHANNELS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= G_RD;
                    end
                end
                G_DIV2: begin
                    if (div_done) begin
                        if (r_idx == CH_W'(MAX_CHANNELS - 1)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= G_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch   <= in_ch;
            r_smp  <= i_in.sample;
            r_last <= i_in.frame_last;
        end
        if (r_state == S_MUL) begin
            r_prod <= PRD_W'(r_smp) * PRD_W'(adv_rec.gain);
        end
        if (r_state == S_OUT) begin
            r_oprod <= OP_W'(r_acc) * OP_W'(OUT_SCALE);
        end
        if (r_state == S_FIN && fin_go) begin
            r_omix <= ov_sat;
        end
        if (r_state == G_RD) begin
            r_lprod <= DIV_A_W'(r_slew[r_idx]) * DIV_A_W'(r_sr);
        end
        if (r_state == G_CHK) begin
            r_lquo <= lmul[LM_W-1:LEN_RECIP_SH];
        end
        if (r_state == G_DIV1) begin
            r_len <= len_sat;
        end
    end

endmodule

// File: verif/gam_mix_scoreboard.sv
// ----------------------------------------------------------------------------
// gam_mix_scoreboard
// Predicts mixed frame samples of the gated auto-gain mixer and checks them.
// ----------------------------------------------------------------------------
class gam_mix_scoreboard;

    localparam int NCH = 10;

    // configuration copy
    int unsigned chan_count_reg;
    int unsigned rate_reg;
    int unsigned glob_slew_reg;

    // per-channel gain state
    bit          gate_open [NCH];
    int unsigned slew_of   [NCH];
    int unsigned target_q23[NCH];
    bit          ramping   [NCH];
    int          gain_q30  [NCH];
    int          step_q30  [NCH];
    int unsigned ramp_len  [NCH];
    int unsigned ramp_cnt  [NCH];
    int          mix_sum;

    logic signed [23:0] pending_mix[$];
    int unsigned        mismatches;

    function new();
        chan_count_reg = 2;
        rate_reg       = 44100;
        glob_slew_reg  = 0;
        for (int i = 0; i < NCH; i++) begin
            gate_open[i] = 0; slew_of[i] = 0; target_q23[i] = 0; ramping[i] = 0;
            gain_q30[i] = 0; step_q30[i] = 0; ramp_len[i] = 0; ramp_cnt[i] = 0;
        end
        mix_sum    = 0;
        mismatches = 0;
    endfunction

    function int unsigned live_count();
        if (chan_count_reg < 2) return 2;
        if (chan_count_reg > NCH) return NCH;
        return chan_count_reg;
    endfunction

    function void write_reg(logic [1:0] idx, logic [17:0] val);
        case (idx)
            gam_pkg::REG_CHANNEL_COUNT: chan_count_reg = val[3:0];
            gam_pkg::REG_SAMPLE_RATE:   rate_reg = val;
            gam_pkg::REG_GLOBAL_SLEW: begin
                glob_slew_reg = val[15:0];
                for (int i = 0; i < NCH; i++) slew_of[i] = glob_slew_reg;
            end
            default: ;
        endcase
    endfunction

    // round half up of v / 2^30
    function longint rnd30(longint v);
        longint t;
        t = v + (longint'(1) << 29);
        return t >>> 30;
    endfunction

    function void restart(int c);
        int      dest;
        longint  len;
        dest = int'(target_q23[c] << 7);
        if (slew_of[c] == 0) begin
            ramping[c] = 0; gain_q30[c] = dest;
            return;
        end
        len = (longint'(slew_of[c]) * longint'(rate_reg)) / 1000;
        if (len > 24'hFFFFFF) len = 24'hFFFFFF;
        if (len == 0) begin
            ramping[c] = 0; gain_q30[c] = dest; ramp_len[c] = 0; ramp_cnt[c] = 0;
            return;
        end
        ramp_len[c] = len;
        ramp_cnt[c] = 0;
        step_q30[c] = int'((longint'(dest) - longint'(gain_q30[c])) / len);
        ramping[c]  = 1;
    endfunction

    // note one accepted input transaction
    function void note_item(logic rtype, logic [3:0] ch, logic signed [23:0] smp,
                            logic last, logic on, logic given, logic [15:0] ms);
        int unsigned n;
        longint      v;
        if (rtype == gam_pkg::REQ_GATE) begin
            if (ch >= live_count()) return;
            gate_open[ch] = on;
            slew_of[ch]   = given ? ms : glob_slew_reg;
            n = 0;
            for (int i = 0; i < NCH; i++) n += gate_open[i];
            for (int i = 0; i < NCH; i++) begin
                target_q23[i] = (n != 0 && gate_open[i]) ? ((32'd1 << 23) + n / 2) / n : 0;
                restart(i);
            end
            return;
        end
        if (ch < live_count()) begin
            if (ramping[ch]) begin
                ramp_cnt[ch]++;
                if (ramp_cnt[ch] >= ramp_len[ch]) begin
                    gain_q30[ch] = int'(target_q23[ch] << 7);
                    ramping[ch]  = 0;
                end else begin
                    gain_q30[ch] = gain_q30[ch] + step_q30[ch];
                end
            end
            v = longint'(mix_sum) + rnd30(longint'(smp) * longint'(gain_q30[ch]));
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            mix_sum = int'(v);
        end
        if (!last) return;
        v = rnd30(longint'(mix_sum) * longint'(gam_pkg::OUT_SCALE));
        if (v > 8388607) v = 8388607;
        if (v < -8388608) v = -8388608;
        pending_mix.push_back(v[23:0]);
        mix_sum = 0;
    endfunction

    // check one accepted result transaction
    function void check_mix(logic signed [23:0] got);
        logic signed [23:0] want;
        if (pending_mix.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected mix_out %0d", got);
            return;
        end
        want = pending_mix.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mix_out: expected %0d, got %0d", want, got);
        end
    endfunction

endclass

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives samples, gate events and register writes into the gated mixer with
// random idling on both channels and checks each mixed frame sample.
// ----------------------------------------------------------------------------
module tb_top;

    import gam_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gam_in_if  in_ch();
    gam_out_if out_ch();
    gam_cfg_if cfg_ch();

    gated_auto_gain_mixer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    gam_mix_scoreboard mix_sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0; in_ch.req_type = 0; in_ch.channel = 0; in_ch.sample = 0;
        in_ch.frame_last = 0; in_ch.gate_on = 0; in_ch.slew_given = 0;
        in_ch.slew_ms = 0;
        cfg_ch.valid = 0; cfg_ch.index = 0; cfg_ch.data = 0;
        out_ch.ready = 0;
    end

    // randomly stall the result side; check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) mix_sb.check_mix(out_ch.mix_out);
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // valid stays high after a transaction until the next idle cycle or pause
    task automatic send_item(logic rtype, logic [3:0] ch, logic signed [23:0] smp,
                             logic last, logic on, logic given, logic [15:0] ms);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1; in_ch.req_type <= rtype; in_ch.channel <= ch;
        in_ch.sample <= smp; in_ch.frame_last <= last; in_ch.gate_on <= on;
        in_ch.slew_given <= given; in_ch.slew_ms <= ms;
        do @(posedge i_clk); while (!in_ch.ready);
        mix_sb.note_item(rtype, ch, smp, last, on, given, ms);
    endtask

    task automatic send_sample(logic [3:0] ch, logic signed [23:0] smp, logic last);
        send_item(REQ_SAMPLE, ch, smp, last, 1'($urandom), 1'($urandom), 16'($urandom));
    endtask

    task automatic send_gate(logic [3:0] ch, logic on, logic given, logic [15:0] ms);
        send_item(REQ_GATE, ch, 24'($urandom), 1'($urandom), on, given, ms);
    endtask

    // drain, then write one register
    task automatic write_reg(logic [1:0] idx, logic [17:0] val);
        in_ch.valid <= 0;
        while (mix_sb.pending_mix.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
        cfg_ch.valid <= 1; cfg_ch.index <= idx; cfg_ch.data <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        mix_sb.write_reg(idx, val);
        cfg_ch.valid <= 0;
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            default: return 24'($urandom);
        endcase
    endfunction

    // one frame of samples over the live channels, with occasional gate events
    task automatic run_frame(int unsigned nch);
        for (int c = 0; c < nch; c++) begin
            if ($urandom_range(19) == 0)
                send_gate(4'($urandom_range(nch - 1)), 1'($urandom), 1'($urandom),
                          16'($urandom_range(3) == 0 ? $urandom : $urandom_range(40)));
            send_sample(4'(c), rand_sample(), c == nch - 1);
        end
    endtask

    task automatic run_phase(int unsigned items);
        int unsigned sent;
        int unsigned nch;
        sent = 0;
        while (sent < items) begin
            nch = mix_sb.live_count();
            if ($urandom_range(9) == 0) begin
                // noise: any channel field, stray frame ends
                send_item(1'($urandom), 4'($urandom), rand_sample(), 1'($urandom),
                          1'($urandom), 1'($urandom), 16'($urandom));
                sent++;
            end else begin
                run_frame(nch);
                sent += nch;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: gates opening and closing, zero, short and long slews
        send_sample(0, 24'sh7FFFFF, 1);
        send_gate(0, 1, 1, 0);
        send_sample(0, 24'sh7FFFFF, 0);
        send_sample(1, -24'sh800000, 1);
        send_gate(1, 1, 1, 1);
        send_sample(1, 24'sh123456, 1);
        send_gate(1, 1, 1, 16'hFFFF);
        send_gate(5, 1, 0, 0);
        send_sample(7, 24'sh7FFFFF, 1);
        send_gate(0, 0, 0, 3);
        send_sample(0, 24'sh400000, 0);
        send_sample(1, -24'sh800000, 1);
        send_sample(1, 24'sh7FFFFF, 1);
        send_gate(0, 0, 1, 0);
        send_gate(1, 0, 1, 0);
        send_sample(0, 24'sh000001, 1);

        // extremes: ten channels, huge rate and slew, saturating sums
        write_reg(REG_CHANNEL_COUNT, 18'd10);
        write_reg(REG_SAMPLE_RATE, 18'd192000);
        write_reg(REG_GLOBAL_SLEW, 18'd65535);
        for (int c = 0; c < 10; c++) send_gate(4'(c), 1, 1, 0);
        for (int c = 0; c < 10; c++) send_sample(4'(c), 24'sh7FFFFF, c == 9);
        send_gate(9, 0, 0, 0);
        for (int c = 0; c < 10; c++) send_sample(4'(c), -24'sh800000, c == 9);

        send_idle_pct = 16; recv_idle_pct = 66;
        write_reg(REG_SAMPLE_RATE, 18'd1);
        write_reg(REG_GLOBAL_SLEW, 18'd999);
        run_phase(300);

        write_reg(REG_CHANNEL_COUNT, 18'd15);
        write_reg(REG_SAMPLE_RATE, 18'd48000);
        write_reg(REG_GLOBAL_SLEW, 18'd1);
        send_idle_pct = 66; recv_idle_pct = 16;
        run_phase(300);

        write_reg(REG_CHANNEL_COUNT, 18'd0);
        write_reg(REG_SAMPLE_RATE, 18'h3FFFF);
        write_reg(REG_GLOBAL_SLEW, 18'd0);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_phase(250);

        write_reg(REG_CHANNEL_COUNT, 18'd5);
        write_reg(REG_SAMPLE_RATE, 18'd8000);
        run_phase(250);

        in_ch.valid <= 0;
        while (mix_sb.pending_mix.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mix_sb.mismatches == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/gam_pkg.sv
rtl/gam_if.sv
rtl/gam_div.sv
rtl/gated_auto_gain_mixer.sv
verif/gam_mix_scoreboard.sv
verif/tb_top.sv
